[src/spe_pkg.sv]
// Shared constants, lane types and constant tables for the sine position encoder.
`timescale 1ns / 1ps
package spe_pkg;

   localparam int MAX_SIDE     = 1024;
   localparam int MAX_PAIRS    = 256;
   localparam int CORDIC_STEPS = 16;

   localparam int IDX_W   = 10;
   localparam int PAIR_W  = 8;
   localparam int CFG_W   = 24;
   localparam int FRAC_W  = 20;
   localparam int E_W     = PAIR_W + CFG_W;
   localparam int K_W     = E_W - FRAC_W;
   localparam int ACC_W   = IDX_W + 1 + CFG_W;
   localparam int MULT_W  = 31;
   localparam int T_W     = 30;
   localparam int XY_W    = 34;
   localparam int Z_W     = 33;
   localparam int OUT_W   = 16;
   localparam int SHIFT_W = 5;

   localparam int REDUCE_STAGES = 8;
   localparam int SPE_LATENCY   = 2 + FRAC_W + REDUCE_STAGES + CORDIC_STEPS + 1;

   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [31:0] PI_Q30         = 32'd3373259426;
   localparam logic [29:0] GAIN_Q30       = 30'd652032874;

   typedef enum logic [1:0] {
      CSR_SCALE_X  = 2'd0,
      CSR_SCALE_Y  = 2'd1,
      CSR_EXP_STEP = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic              valid;
      logic [MULT_W-1:0] mult;
      logic [FRAC_W-1:0] f;
      logic [K_W-1:0]    k;
      logic [ACC_W-1:0]  a_y;
      logic [ACC_W-1:0]  a_x;
   } pow_lane_type;

   typedef struct packed {
      logic                   valid;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [1:0]             q;
   } cordic_lane_type;

   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned rem_v;
      longint unsigned r;
      longint unsigned bit_v;
      rem_v = v;
      r     = 0;
      bit_v = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (bit_v > rem_v) bit_v = bit_v >> 2;
      end
      for (int n = 0; n < 32; n++) begin
         if (bit_v != 0) begin
            if (rem_v >= r + bit_v) begin
               rem_v = rem_v - (r + bit_v);
               r     = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return r;
   endfunction

   // 2^(-2^-(idx+1)) in Q0.30, each entry the square root of the one before
   function automatic logic [T_W-1:0] frac_entry(input int idx);
      longint unsigned prev;
      logic [T_W-1:0]  res;
      prev = 64'd1 << 29;
      res  = '0;
      for (int i = 0; i < FRAC_W; i++) begin
         prev = isqrt64(prev << 30);
         if (i == idx) res = prev[T_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [29:0] atan_entry(input int idx);
      logic [29:0] v;
      case (idx)
         0:       v = 30'h3243F6A8;
         1:       v = 30'h1DAC6705;
         2:       v = 30'h0FADBAFC;
         3:       v = 30'h07F56EA6;
         4:       v = 30'h03FEAB76;
         5:       v = 30'h01FFD55B;
         6:       v = 30'h00FFFAAA;
         7:       v = 30'h007FFF55;
         8:       v = 30'h003FFFEA;
         9:       v = 30'h001FFFFD;
         10:      v = 30'h000FFFFF;
         11:      v = 30'h0007FFFF;
         12:      v = 30'h0003FFFF;
         13:      v = 30'h0001FFFF;
         14:      v = 30'h0000FFFF;
         15:      v = 30'h00007FFF;
         16:      v = 30'h00003FFF;
         17:      v = 30'h00001FFF;
         18:      v = 30'h00000FFF;
         19:      v = 30'h000007FF;
         20:      v = 30'h000003FF;
         21:      v = 30'h000001FF;
         22:      v = 30'h000000FF;
         23:      v = 30'h0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[src/sine_position_encoding_top.sv]
// Top level of the sine position encoder: input stage, power chain, two CORDIC rows.
// Throughput: one item per clock; busy is held low, every start is taken.
// Reset (synchronous, active high) drops all items in flight and loads the
// register reset values; there is no clearing pass.
// The receiver cannot stall: each result shows for one cycle with rsp_valid.
`timescale 1ns / 1ps
module sine_position_encoding_top
   import spe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [IDX_W-1:0]        req_row,
   input  logic [IDX_W-1:0]        req_column,
   input  logic [PAIR_W-1:0]       req_pair,
   input  logic                    csr_we,
   input  logic [1:0]              csr_idx,
   input  logic [CFG_W-1:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_sin_y,
   output logic signed [OUT_W-1:0] rsp_cos_y,
   output logic signed [OUT_W-1:0] rsp_sin_x,
   output logic signed [OUT_W-1:0] rsp_cos_x
);

   // Configuration registers
   logic [CFG_W-1:0] scale_x_ff;
   logic [CFG_W-1:0] scale_y_ff;
   logic [CFG_W-1:0] exp_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= CFG_W'(6588397);
         scale_y_ff  <= CFG_W'(6588397);
         exp_step_ff <= CFG_W'(217706);
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_SCALE_X:  scale_x_ff  <= csr_wdata;
            CSR_SCALE_Y:  scale_y_ff  <= csr_wdata;
            CSR_EXP_STEP: exp_step_ff <= csr_wdata;
            default:      ; // unused index: drop the write
         endcase
      end
   end

   // Every cycle is open to a new item
   assign busy = 1'b0;

   // Stage 0: clamp indices to their legal range
   logic              s0_valid_ff;
   logic [IDX_W-1:0]  s0_row_ff;
   logic [IDX_W-1:0]  s0_col_ff;
   logic [PAIR_W-1:0] s0_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_row_ff  <= (int'(req_row) >= MAX_SIDE) ? IDX_W'(MAX_SIDE - 1) : req_row;
      s0_col_ff  <= (int'(req_column) >= MAX_SIDE) ? IDX_W'(MAX_SIDE - 1) : req_column;
      s0_pair_ff <= (int'(req_pair) >= MAX_PAIRS) ? PAIR_W'(MAX_PAIRS - 1) : req_pair;
   end

   // Stage 1: exponent pair*step split into shift k and fraction f,
   // and the linear angle factors (index+1)*scale for both axes
   pow_lane_type    pow_in;
   pow_lane_type    pow_ff;
   logic [E_W-1:0]  e;

   always_comb begin
      e            = s0_pair_ff * exp_step_ff;
      pow_in.valid = s0_valid_ff;
      pow_in.mult  = MULT_W'(1) << 30;
      pow_in.f     = e[FRAC_W-1:0];
      pow_in.k     = e[E_W-1:FRAC_W];
      pow_in.a_y   = ({1'b0, s0_row_ff} + (IDX_W+1)'(1)) * scale_y_ff;
      pow_in.a_x   = ({1'b0, s0_col_ff} + (IDX_W+1)'(1)) * scale_x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pow_ff.valid <= 1'b0;
      end else begin
         pow_ff <= pow_in;
      end
   end

   // Power chain: one cell per fraction bit, most significant first,
   // each multiplying by its root of one half when the bit is set
   pow_lane_type pow_lane [FRAC_W+1];
   assign pow_lane[0] = pow_ff;

   for (genvar gi = 0; gi < FRAC_W; gi++) begin : g_pow
      spe_pow_cell u_pow (
         .clock   (clock),
         .reset   (reset),
         .in_lane (pow_lane[gi]),
         .in_t    (frac_entry(gi)),
         .out_lane(pow_lane[gi+1])
      );
   end

   // Per-axis reduction to an octant angle and a quadrant
   cordic_lane_type y_lane [CORDIC_STEPS+1];
   cordic_lane_type x_lane [CORDIC_STEPS+1];

   spe_reduce u_reduce_y (
      .clock   (clock),
      .reset   (reset),
      .in_valid(pow_lane[FRAC_W].valid),
      .in_a    (pow_lane[FRAC_W].a_y),
      .in_mult (pow_lane[FRAC_W].mult),
      .in_k    (pow_lane[FRAC_W].k),
      .out_lane(y_lane[0])
   );

   spe_reduce u_reduce_x (
      .clock   (clock),
      .reset   (reset),
      .in_valid(pow_lane[FRAC_W].valid),
      .in_a    (pow_lane[FRAC_W].a_x),
      .in_mult (pow_lane[FRAC_W].mult),
      .in_k    (pow_lane[FRAC_W].k),
      .out_lane(x_lane[0])
   );

   // Two CORDIC rows, one rotation per cell
   for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
      spe_cordic_cell u_cell_y (
         .clock   (clock),
         .reset   (reset),
         .in_lane (y_lane[gi]),
         .in_shift(SHIFT_W'(gi)),
         .in_atan (atan_entry(gi)),
         .out_lane(y_lane[gi+1])
      );
      spe_cordic_cell u_cell_x (
         .clock   (clock),
         .reset   (reset),
         .in_lane (x_lane[gi]),
         .in_shift(SHIFT_W'(gi)),
         .in_atan (atan_entry(gi)),
         .out_lane(x_lane[gi+1])
      );
   end

   // Round to Q1.15 with saturation
   function automatic logic [OUT_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
      logic signed [XY_W:0] t;
      logic signed [XY_W:0] s;
      logic [OUT_W-1:0]     res;
      t = $signed({v[XY_W-1], v}) + $signed((XY_W+1)'(1 << 14));
      s = t >>> 15;
      if (s > $signed((XY_W+1)'(32767)))       res = 16'h7FFF;
      else if (s < -$signed((XY_W+1)'(32768))) res = 16'h8000;
      else                                     res = s[OUT_W-1:0];
      return res;
   endfunction

   // Unfold the quadrant, then round both values
   function automatic logic [2*OUT_W-1:0] unfold(input cordic_lane_type l);
      logic signed [XY_W-1:0] s;
      logic signed [XY_W-1:0] c;
      case (l.q)
         2'd1: begin
            s = l.x;
            c = -l.y;
         end
         2'd2: begin
            s = -l.y;
            c = -l.x;
         end
         2'd3: begin
            s = -l.x;
            c = l.y;
         end
         default: begin
            s = l.y;
            c = l.x;
         end
      endcase
      return {to_q15(s), to_q15(c)};
   endfunction

   // Output register: present each result for one cycle
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] sin_y_ff;
   logic [OUT_W-1:0] cos_y_ff;
   logic [OUT_W-1:0] sin_x_ff;
   logic [OUT_W-1:0] cos_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= y_lane[CORDIC_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      {sin_y_ff, cos_y_ff} <= unfold(y_lane[CORDIC_STEPS]);
      {sin_x_ff, cos_x_ff} <= unfold(x_lane[CORDIC_STEPS]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sin_y = $signed(sin_y_ff);
   assign rsp_cos_y = $signed(cos_y_ff);
   assign rsp_sin_x = $signed(sin_x_ff);
   assign rsp_cos_x = $signed(cos_x_ff);

endmodule

[src/spe_pow_cell.sv]
// One fraction bit of the 2^(-f) product: conditional multiply by a table root.
`timescale 1ns / 1ps
module spe_pow_cell
   import spe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pow_lane_type in_lane,
   input  logic [T_W-1:0] in_t,
   output pow_lane_type out_lane
);

   pow_lane_type                lane_in;
   pow_lane_type                lane_ff;
   logic [MULT_W+T_W-1:0]       prod;

   always_comb begin
      prod    = in_lane.mult * in_t;
      lane_in = in_lane;
      // test the top fraction bit, then advance the next one into place
      if (in_lane.f[FRAC_W-1]) lane_in.mult = prod[MULT_W+T_W-1:T_W];
      lane_in.f = {in_lane.f[FRAC_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign out_lane = lane_ff;

endmodule

[src/spe_reduce.sv]
// Angle product, turn phase, octant reduction and CORDIC seed for one axis.
`timescale 1ns / 1ps
module spe_reduce
   import spe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [ACC_W-1:0]  in_a,
   input  logic [MULT_W-1:0] in_mult,
   input  logic [K_W-1:0]    in_k,
   output cordic_lane_type   out_lane
);

   logic [REDUCE_STAGES-1:0] valid_ff;
   logic [REDUCE_STAGES-1:0] valid_in;

   logic [62:0]     plo_ff;
   logic [33:0]     phi_ff;
   logic [K_W-1:0]  k1_ff;
   logic [63:0]     prod_ff;
   logic [K_W-1:0]  k2_ff;
   logic [33:0]     ang_ff;
   logic [61:0]     qlo_ff;
   logic [31:0]     qhi_ff;
   logic [31:0]     ph_ff;
   logic [1:0]      q6_ff;
   logic            neg6_ff;
   logic [29:0]     mag_ff;
   logic [1:0]      q7_ff;
   logic            neg7_ff;
   logic [30:0]     zm_ff;
   cordic_lane_type lane_ff;

   logic [6:0]      sh;
   logic [63:0]     shifted;
   logic [63:0]     qsum;
   logic [31:0]     t;
   logic signed [30:0] r;
   logic [61:0]     zprod;

   always_comb begin
      valid_in = {valid_ff[REDUCE_STAGES-2:0], in_valid};
      sh       = 7'd30 + {1'b0, k2_ff[5:0]};
      shifted  = prod_ff >> sh;
      qsum     = {2'b00, qlo_ff} + {qhi_ff, 32'd0};
      t        = ph_ff + 32'h2000_0000;
      r        = $signed({1'b0, t[29:0]}) - 31'sh2000_0000;
      zprod    = mag_ff * PI_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plo_ff  <= in_a[31:0] * in_mult;
      phi_ff  <= in_a[ACC_W-1:32] * in_mult;
      k1_ff   <= in_k;
      prod_ff <= {1'b0, plo_ff} + {phi_ff[31:0], 32'd0};
      k2_ff   <= k1_ff;
      // a total shift of 64 or more drops the angle to zero
      ang_ff  <= (k2_ff >= K_W'(34)) ? '0 : shifted[33:0];
      qlo_ff  <= ang_ff[31:0] * INV_TWO_PI_Q32;
      qhi_ff  <= ang_ff[33:32] * INV_TWO_PI_Q32;
      ph_ff   <= qsum[51:20];
      q6_ff   <= t[31:30];
      neg6_ff <= r[30];
      mag_ff  <= r[30] ? 30'(-r) : 30'(r);
      q7_ff   <= q6_ff;
      neg7_ff <= neg6_ff;
      zm_ff   <= zprod[61:31];
      lane_ff.valid <= valid_ff[REDUCE_STAGES-2];
      lane_ff.x <= XY_W'(GAIN_Q30);
      lane_ff.y <= '0;
      lane_ff.z <= neg7_ff ? -$signed({2'b00, zm_ff}) : $signed({2'b00, zm_ff});
      lane_ff.q <= q7_ff;
   end

   always_comb begin
      out_lane       = lane_ff;
      out_lane.valid = valid_ff[REDUCE_STAGES-1];
   end

endmodule

[src/spe_cordic_cell.sv]
// One CORDIC rotation step; hands x, y, z and quadrant to the next cell.
`timescale 1ns / 1ps
module spe_cordic_cell
   import spe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cordic_lane_type in_lane,
   input  logic [SHIFT_W-1:0] in_shift,
   input  logic [29:0]     in_atan,
   output cordic_lane_type out_lane
);

   cordic_lane_type        lane_in;
   cordic_lane_type        lane_ff;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [Z_W-1:0]  da;

   always_comb begin
      dx      = in_lane.y >>> in_shift;
      dy      = in_lane.x >>> in_shift;
      da      = $signed({3'b000, in_atan});
      lane_in = in_lane;
      if (!in_lane.z[Z_W-1]) begin
         lane_in.x = in_lane.x - dx;
         lane_in.y = in_lane.y + dy;
         lane_in.z = in_lane.z - da;
      end else begin
         lane_in.x = in_lane.x + dx;
         lane_in.y = in_lane.y - dy;
         lane_in.z = in_lane.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign out_lane = lane_ff;

endmodule

[src/spe_checker.sv]
// Port-level assertions for the sine position encoder, bound to the top level.
`timescale 1ns / 1ps
module spe_checker
   import spe_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [IDX_W-1:0]        req_row,
   input logic [IDX_W-1:0]        req_column,
   input logic [PAIR_W-1:0]       req_pair,
   input logic                    csr_we,
   input logic [1:0]              csr_idx,
   input logic [CFG_W-1:0]        csr_wdata,
   input logic                    rsp_valid,
   input logic signed [OUT_W-1:0] rsp_sin_y,
   input logic signed [OUT_W-1:0] rsp_cos_y,
   input logic signed [OUT_W-1:0] rsp_sin_x,
   input logic signed [OUT_W-1:0] rsp_cos_x
);

   a_no_stall: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_no_result_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, SPE_LATENCY))
      else $error("result without matching item");

   a_unit_circle_y: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((int'(rsp_sin_y) * int'(rsp_sin_y) + int'(rsp_cos_y) * int'(rsp_cos_y)
                      > 1056964608) &&
                     (int'(rsp_sin_y) * int'(rsp_sin_y) + int'(rsp_cos_y) * int'(rsp_cos_y)
                      < 1090519040)))
      else $error("vertical pair off the unit circle");

   a_unit_circle_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((int'(rsp_sin_x) * int'(rsp_sin_x) + int'(rsp_cos_x) * int'(rsp_cos_x)
                      > 1056964608) &&
                     (int'(rsp_sin_x) * int'(rsp_sin_x) + int'(rsp_cos_x) * int'(rsp_cos_x)
                      < 1090519040)))
      else $error("horizontal pair off the unit circle");

endmodule

bind sine_position_encoding_top spe_checker u_spe_checker (.*);

[bench/sine_position_encoding_top_tb.sv]
// Self-checking testbench for the sine position encoder: directed table, then random items.
`timescale 1ns / 1ps
module sine_position_encoding_top_tb;
   import spe_pkg::*;

   // Writes to this index must be ignored by the block.
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int         RUN_LIMIT    = 200000;
   localparam logic signed [15:0] FULL_COS = 16'sd32767;
   localparam logic signed [15:0] ZERO_SIN = -16'sd1;

   typedef struct packed {
      logic signed [OUT_W-1:0] sin_y;
      logic signed [OUT_W-1:0] cos_y;
      logic signed [OUT_W-1:0] sin_x;
      logic signed [OUT_W-1:0] cos_x;
   } encoding_type;

   typedef struct {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  column;
      logic [PAIR_W-1:0] pair;
      bit                typed;
      encoding_type      value;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [IDX_W-1:0]        req_row;
   logic [IDX_W-1:0]        req_column;
   logic [PAIR_W-1:0]       req_pair;
   logic                    csr_we;
   logic [1:0]              csr_idx;
   logic [CFG_W-1:0]        csr_wdata;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_sin_y;
   logic signed [OUT_W-1:0] rsp_cos_y;
   logic signed [OUT_W-1:0] rsp_sin_x;
   logic signed [OUT_W-1:0] rsp_cos_x;

   // Predictor copy of the registers
   longint unsigned scale_x_q;
   longint unsigned scale_y_q;
   longint unsigned exp_step_q;

   longint unsigned half_power[FRAC_W];
   longint          arctan_q30[24];

   encoding_type pending_enc[$];
   int unsigned  fail_count;
   int unsigned  items_sent;
   int unsigned  results_seen;
   int unsigned  cycle_count;
   int           burst_left;

   sine_position_encoding_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_row    (req_row),
      .req_column (req_column),
      .req_pair   (req_pair),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_sin_y  (rsp_sin_y),
      .rsp_cos_y  (rsp_cos_y),
      .rsp_sin_x  (rsp_sin_x),
      .rsp_cos_x  (rsp_cos_x)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Integer square root, bit by bit
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned rem_v;
      longint unsigned root;
      longint unsigned probe;
      rem_v = v;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem_v && probe != 0) probe = probe >> 2;
      while (probe != 0) begin
         if (rem_v >= root + probe) begin
            rem_v = rem_v - (root + probe);
            root  = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Round a Q2.30 value to Q1.15 and clamp
   function automatic logic signed [OUT_W-1:0] round_q15(input longint v);
      longint r;
      r = (v + (64'sd1 << 14)) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[OUT_W-1:0];
   endfunction

   // sin/cos of (idx+1)*scale*mult*2^-k, returned as {sin, cos}
   function automatic logic [2*OUT_W-1:0] sincos_angle(input longint unsigned idx,
         input longint unsigned scale, input longint unsigned mult, input longint unsigned k);
      longint unsigned acc;
      longint unsigned angle;
      longint unsigned ph;
      longint unsigned qq;
      longint unsigned mag;
      longint          r;
      longint          z;
      longint          x;
      longint          y;
      longint          dx;
      longint          dy;
      longint          s;
      longint          c;
      longint          t;
      acc   = (idx + 1) * scale;
      angle = 0;
      if (30 + k < 64) angle = (acc * mult) >> (30 + k);
      ph  = ((angle * 64'd683565276) >> 20) & 64'hFFFF_FFFF;
      qq  = (ph + (64'd1 << 29)) >> 30;
      r   = longint'(ph) - longint'(qq << 30);
      mag = (r < 0) ? -r : r;
      z   = longint'((mag * 64'd3373259426) >> 31);
      if (r < 0) z = -z;
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - arctan_q30[i];
         end else begin
            x = x + dx; y = y - dy; z = z + arctan_q30[i];
         end
      end
      s = y;
      c = x;
      case (qq[1:0])
         2'd1: begin t = s; s = c; c = -t; end
         2'd2: begin s = -s; c = -c; end
         2'd3: begin t = s; s = -c; c = t; end
         default: ;
      endcase
      return {round_q15(s), round_q15(c)};
   endfunction

   function automatic encoding_type predict_encoding(input logic [IDX_W-1:0] row,
         input logic [IDX_W-1:0] column, input logic [PAIR_W-1:0] pair);
      longint unsigned e;
      longint unsigned f;
      longint unsigned mult;
      encoding_type    enc;
      e    = longint'(pair) * exp_step_q;
      f    = e & ((64'd1 << FRAC_W) - 1);
      mult = 64'd1 << 30;
      for (int i = 0; i < FRAC_W; i++) begin
         if (f[FRAC_W-1-i]) mult = (mult * half_power[i]) >> 30;
      end
      {enc.sin_y, enc.cos_y} = sincos_angle(row, scale_y_q, mult, e >> FRAC_W);
      {enc.sin_x, enc.cos_x} = sincos_angle(column, scale_x_q, mult, e >> FRAC_W);
      return enc;
   endfunction

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      encoding_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_enc.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            want = pending_enc.pop_front();
            if (rsp_sin_y !== want.sin_y) begin
               $error("sin_y expected %0d got %0d", want.sin_y, rsp_sin_y);
               fail_count++;
            end
            if (rsp_cos_y !== want.cos_y) begin
               $error("cos_y expected %0d got %0d", want.cos_y, rsp_cos_y);
               fail_count++;
            end
            if (rsp_sin_x !== want.sin_x) begin
               $error("sin_x expected %0d got %0d", want.sin_x, rsp_sin_x);
               fail_count++;
            end
            if (rsp_cos_x !== want.cos_x) begin
               $error("cos_x expected %0d got %0d", want.cos_x, rsp_cos_x);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Write one register; block is idle whenever this is called
   task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SCALE_X:  scale_x_q  = value;
         CSR_SCALE_Y:  scale_y_q  = value;
         CSR_EXP_STEP: exp_step_q = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
         input logic [CFG_W-1:0] es);
      write_reg(CSR_SCALE_X, sx);
      write_reg(CSR_SCALE_Y, sy);
      write_reg(CSR_EXP_STEP, es);
      // an unmapped index must leave all three registers alone
      write_reg(CSR_UNMAPPED, CFG_W'($urandom));
   endtask

   // Drain the pipeline before touching the registers
   task automatic drain;
      start <= 1'b0;
      while (pending_enc.size() != 0) @(posedge clock);
      repeat (SPE_LATENCY + 4) @(posedge clock);
   endtask

   // Present one item; start stays high on return so bursts run back to back
   task automatic send_item(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] column,
         input logic [PAIR_W-1:0] pair, input bit typed, input encoding_type value);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start      <= 1'b1;
      req_row    <= row;
      req_column <= column;
      req_pair   <= pair;
      do @(posedge clock); while (busy);
      pending_enc.insert(pending_enc.size(),
                         typed ? value : predict_encoding(row, column, pair));
      items_sent++;
   endtask

   task automatic random_items(input int count);
      logic [PAIR_W-1:0] pair;
      for (int n = 0; n < count; n++) begin
         // mostly the low pairs, where the angle is large and wraps many turns
         pair = ($urandom_range(0, 2) == 0) ? PAIR_W'($urandom_range(0, 255))
                                             : PAIR_W'($urandom_range(0, 40));
         send_item(IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
                   pair, 1'b0, '0);
      end
   endtask

   stim_row_type directed[20];
   encoding_type flat_enc;

   initial begin
      longint unsigned prev;
      arctan_q30 = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
                     32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
                     32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
                     32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
                     32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
                     32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};
      // each entry is the square root of the one before, starting from one half
      prev = 64'd1 << 29;
      for (int i = 0; i < FRAC_W; i++) begin
         prev          = int_sqrt(prev << 30);
         half_power[i] = prev;
      end

      // zero angle: the rotations leave a small negative residual angle, so
      // sine rounds to -1; cosine clamps at full scale
      flat_enc = '{ZERO_SIN, FULL_COS, ZERO_SIN, FULL_COS};
      directed = '{
         '{10'd0,    10'd0,    8'd0,   1'b0, '0},
         '{10'd1023, 10'd1023, 8'd0,   1'b0, '0},
         '{10'd0,    10'd1023, 8'd0,   1'b0, '0},
         '{10'd1023, 10'd0,    8'd1,   1'b0, '0},
         '{10'd511,  10'd512,  8'd3,   1'b0, '0},
         '{10'd341,  10'd682,  8'd7,   1'b0, '0},
         '{10'd3,    10'd5,    8'd16,  1'b0, '0},
         '{10'd31,   10'd15,   8'd63,  1'b0, '0},
         '{10'd1023, 10'd1023, 8'd64,  1'b0, '0},
         '{10'd100,  10'd200,  8'd127, 1'b0, '0},
         '{10'd1023, 10'd1023, 8'd150, 1'b0, '0},
         '{10'd0,    10'd0,    8'd170, 1'b0, '0},
         // shift past 64: angle collapses to zero
         '{10'd0,    10'd0,    8'd255, 1'b1, flat_enc},
         '{10'd1023, 10'd1023, 8'd255, 1'b1, flat_enc},
         '{10'd682,  10'd341,  8'd200, 1'b1, flat_enc},
         '{10'd7,    10'd9,    8'd2,   1'b0, '0},
         '{10'd255,  10'd256,  8'd4,   1'b0, '0},
         '{10'd12,   10'd24,   8'd8,   1'b0, '0},
         '{10'd48,   10'd96,   8'd32,  1'b0, '0},
         '{10'd900,  10'd800,  8'd128, 1'b0, '0}
      };

      scale_x_q   = 6588397;
      scale_y_q   = 6588397;
      exp_step_q  = 217706;
      fail_count  = 0;
      items_sent  = 0;
      results_seen = 0;
      cycle_count = 0;
      burst_left  = 0;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_row    <= '0;
      req_column <= '0;
      req_pair   <= '0;
      csr_we     <= 1'b0;
      csr_idx    <= CSR_SCALE_X;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table on the reset register values
      foreach (directed[i])
         send_item(directed[i].row, directed[i].column, directed[i].pair,
                   directed[i].typed, directed[i].value);
      random_items(80);
      drain();

      // zero scales: every angle is zero
      set_config(24'd0, 24'd0, 24'hFFFFFF);
      for (int n = 0; n < 5; n++)
         send_item(IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
                   PAIR_W'($urandom_range(0, 255)), 1'b1, flat_enc);
      drain();

      // all registers at full scale
      set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      random_items(70);
      drain();

      // zero exponent step: the power term stays at one
      set_config(24'hFFFFFF, 24'd205887, 24'd0);
      random_items(70);
      drain();

      // small realistic grid, fine exponent step
      set_config(24'd205887, 24'd102943, 24'd108853);
      random_items(70);
      drain();

      // fully random register values
      for (int p = 0; p < 3; p++) begin
         set_config(CFG_W'($urandom), CFG_W'($urandom),
                    CFG_W'($urandom_range(0, 24'hFFFFFF)));
         random_items(60);
         drain();
      end

      // back to the reset values, to see them restored through the port
      set_config(24'd6588397, 24'd6588397, 24'd217706);
      random_items(70);
      drain();

      $display("%0d items sent, %0d results checked over 9 register settings",
               items_sent, results_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
